### rtl/mpa_pkg.sv
// mpa_pkg: shared constants, register codes, state and handshake types
// for the max pooling with argmax block; no dependencies
package mpa_pkg;

	localparam int MAX_KERNEL_DEF  = 7;
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int PLANE_LIMIT   = 1024;
	localparam int COORD_BITS    = 10;
	localparam int INDEX_BITS    = 11;
	localparam int BASE_BITS     = 12;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 11;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_KERNEL  = 3'd0,
		REG_STRIDE  = 3'd1,
		REG_PADDING = 3'd2,
		REG_HEIGHT  = 3'd3,
		REG_WIDTH   = 3'd4
	} cfg_reg_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CFIND = 8'b0000_0010,
		ST_RFIND = 8'b0000_0100,
		ST_WSET  = 8'b0000_1000,
		ST_SCAN  = 8'b0001_0000,
		ST_DRAIN = 8'b0010_0000,
		ST_EMIT  = 8'b0100_0000,
		ST_ADV   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic write;
		logic start;
		logic col_step;
		logic row_step;
		logic mark;
		logic wset;
		logic scan;
		logic emit;
		logic next_col;
		logic next_row;
		logic adv;
	} cmd_t;

	typedef struct packed {
		logic col_hit;
		logic row_hit;
		logic any_win;
		logic win_empty;
		logic scan_last;
		logic ow_more;
		logic oh_more;
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic                  hit;
		logic                  empty;
		logic [COORD_BITS-1:0] start;
	} axis_t;

endpackage

### rtl/mpa_if.sv
// mpa_if: valid/ready channel interfaces for samples, results and configuration
// depends on mpa_pkg
interface mpa_in_if #(parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mpa_out_if #(parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF);
	logic                                   valid;
	logic                                   ready;
	logic signed [SAMPLE_BITS-1:0]          max_value;
	logic        [mpa_pkg::COORD_BITS-1:0]  max_row;
	logic        [mpa_pkg::COORD_BITS-1:0]  max_col;
	logic        [mpa_pkg::COORD_BITS-1:0]  out_row;
	logic        [mpa_pkg::COORD_BITS-1:0]  out_col;
	logic                                   empty_res;
	logic                                   last;
	modport source (output valid, output max_value, output max_row, output max_col,
		output out_row, output out_col, output empty_res, output last, input ready);
	modport sink (input valid, input max_value, input max_row, input max_col,
		input out_row, input out_col, input empty_res, input last, output ready);
endinterface

interface mpa_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mpa_pkg::CFG_IDX_BITS-1:0]   index;
	logic [mpa_pkg::CFG_DATA_BITS-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mpa_ram.sv
// mpa_ram: generic single-write, single-read memory with registered read
// no dependencies
module mpa_ram #(
	parameter int WIDTH     = 16,
	parameter int DEPTH     = 1024,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/mpa_ctrl.sv
// mpa_ctrl: sequencer that walks window search, sample scan and result hand-off
// depends on mpa_pkg
module mpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mpa_pkg::status_t  status,
	output mpa_pkg::cmd_t     cmd
);
	import mpa_pkg::*;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.write = 1'b1;
					cmd.start = 1'b1;
					state_d   = ST_CFIND;
				end
			end
			ST_CFIND: begin
				if (status.col_hit) begin
					cmd.col_step = 1'b1;
				end else begin
					state_d = ST_RFIND;
				end
			end
			ST_RFIND: begin
				if (status.row_hit) begin
					cmd.row_step = 1'b1;
				end else begin
					cmd.mark = 1'b1;
					state_d  = status.any_win ? ST_WSET : ST_ADV;
				end
			end
			ST_WSET: begin
				cmd.wset = 1'b1;
				state_d  = status.win_empty ? ST_EMIT : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					priority if (status.ow_more) begin
						cmd.next_col = 1'b1;
						state_d      = ST_WSET;
					end else if (status.oh_more) begin
						cmd.next_row = 1'b1;
						state_d      = ST_WSET;
					end else begin
						state_d = ST_ADV;
					end
				end
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### rtl/mpa_dp.sv
// mpa_dp: configuration, plane position, window pointers, line store and max search
// depends on mpa_pkg and mpa_ram
module mpa_dp #(
	parameter int MAX_KERNEL  = mpa_pkg::MAX_KERNEL_DEF,
	parameter int MAX_WIDTH   = mpa_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [mpa_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [mpa_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  mpa_pkg::cmd_t                         cmd,
	output mpa_pkg::status_t                      status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         max_value,
	output logic [mpa_pkg::COORD_BITS-1:0]        max_row,
	output logic [mpa_pkg::COORD_BITS-1:0]        max_col,
	output logic [mpa_pkg::COORD_BITS-1:0]        out_row,
	output logic [mpa_pkg::COORD_BITS-1:0]        out_col,
	output logic                                  empty_res,
	output logic                                  last
);
	import mpa_pkg::*;

	localparam int SLB       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int RAM_DEPTH = MAX_KERNEL * (2 ** CW);
	localparam int RAM_AB    = $clog2(RAM_DEPTH);
	localparam int WCAP      = (MAX_WIDTH < PLANE_LIMIT) ? MAX_WIDTH : PLANE_LIMIT;
	localparam logic signed [SAMPLE_BITS-1:0] MIN_VALUE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// configuration registers
	logic [2:0]  kernel_q, stride_q;
	logic [1:0]  pad_q;
	logic [10:0] height_q, width_q;

	// plane position
	logic [COORD_BITS-1:0] row_q, col_q;
	logic [SLB-1:0]        slot_q;

	// window pointers: index and origin base (index * stride)
	logic [INDEX_BITS-1:0] oh_ptr_q, ow_ptr_q, cur_oh_q, cur_ow_q, oh_end_q, ow_end_q;
	logic [BASE_BITS-1:0]  rb_ptr_q, cb_ptr_q, cur_rb_q, cur_cb_q, rb_end_q, cb_end_q;

	// scan iterators
	logic [COORD_BITS-1:0] h_it_q, w_it_q, ws_q;
	logic [SLB-1:0]        slot_it_q;
	logic                  first_q, empty_q;

	logic                  valid_s1, first_s1;
	logic [COORD_BITS-1:0] h_s1, w_s1;

	logic signed [SAMPLE_BITS-1:0] best_q;
	logic [COORD_BITS-1:0]         br_q, bc_q;

	logic [4:0]  ke;
	logic [2:0]  se;
	logic [10:0] he_len, we_len;
	axis_t       ra, ca;

	logic [SLB-1:0]             d_rows, slot_start;
	logic [COORD_BITS-1:0]      d_full;
	logic [SLB:0]               slot_wide;
	logic [CW+COORD_BITS-1:0]   wcol_ext, rcol_ext;
	logic [SLB+CW-1:0]          waddr_full, raddr_full;
	logic [SAMPLE_BITS-1:0]     rdata;
	logic                       cfg_hit, eol, eop;

	function automatic axis_t axis_eval(
		input logic [BASE_BITS-1:0]  base,
		input logic [10:0]           len,
		input logic [COORD_BITS-1:0] pos,
		input logic [4:0]            k,
		input logic [1:0]            p
	);
		logic signed [13:0] org, endp, lim, m, tm, st;
		logic               ok;
		logic [COORD_BITS-1:0] trig;
		axis_t              a;
		org  = $signed({2'b00, base}) - $signed({12'd0, p});
		endp = org + $signed({9'd0, k});
		lim  = $signed({3'd0, len});
		ok   = endp <= (lim + $signed({12'd0, p}));
		m    = (endp < lim) ? endp : lim;
		tm   = m - 14'sd1;
		trig = (m < 14'sd1) ? '0 : tm[COORD_BITS-1:0];
		st   = (org < 14'sd0) ? 14'sd0 : org;
		a.hit   = ok && (trig == pos);
		a.empty = (st >= m);
		a.start = st[COORD_BITS-1:0];
		return a;
	endfunction

	// effective configuration
	always_comb begin
		priority if (kernel_q == 3'd0) begin
			ke = 5'd1;
		end else if ({2'b00, kernel_q} > 5'(MAX_KERNEL)) begin
			ke = 5'(MAX_KERNEL);
		end else begin
			ke = {2'b00, kernel_q};
		end
		se = (stride_q == 3'd0) ? 3'd1 : stride_q;
		priority if (height_q == 11'd0) begin
			he_len = 11'd1;
		end else if (height_q > 11'(PLANE_LIMIT)) begin
			he_len = 11'(PLANE_LIMIT);
		end else begin
			he_len = height_q;
		end
		priority if (width_q == 11'd0) begin
			we_len = 11'd1;
		end else if (width_q > 11'(WCAP)) begin
			we_len = 11'(WCAP);
		end else begin
			we_len = width_q;
		end
	end

	assign ra = axis_eval(cur_rb_q, he_len, row_q, ke, pad_q);
	assign ca = axis_eval(cur_cb_q, we_len, col_q, ke, pad_q);

	// line store slot of the window's top row
	assign d_full     = row_q - ra.start;
	assign d_rows     = d_full[SLB-1:0];
	assign slot_wide  = {1'b0, slot_q} + (SLB+1)'(MAX_KERNEL) - {1'b0, d_rows};
	assign slot_start = (slot_q >= d_rows) ? (slot_q - d_rows) : slot_wide[SLB-1:0];

	assign eol = ({1'b0, col_q} == (we_len - 11'd1));
	assign eop = ({1'b0, row_q} == (he_len - 11'd1));

	assign status.col_hit   = ca.hit;
	assign status.row_hit   = ra.hit;
	assign status.any_win   = (cur_oh_q != oh_ptr_q) && (cur_ow_q != ow_ptr_q);
	assign status.win_empty = ra.empty || ca.empty;
	assign status.scan_last = (h_it_q == row_q) && (w_it_q == col_q);
	assign status.ow_more   = (cur_ow_q + INDEX_BITS'(1)) != ow_end_q;
	assign status.oh_more   = (cur_oh_q + INDEX_BITS'(1)) != oh_end_q;
	assign status.out_busy  = out_valid && !out_ready;

	// line store addressing
	assign wcol_ext   = {{CW{1'b0}}, col_q};
	assign rcol_ext   = {{CW{1'b0}}, w_it_q};
	assign waddr_full = {slot_q, wcol_ext[CW-1:0]};
	assign raddr_full = {slot_it_q, rcol_ext[CW-1:0]};

	mpa_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (waddr_full[RAM_AB-1:0]),
		.wdata (sample),
		.re    (cmd.scan),
		.raddr (raddr_full[RAM_AB-1:0]),
		.rdata (rdata)
	);

	assign cfg_hit = cfg_valid && (cfg_index <= CFG_IDX_BITS'(REG_WIDTH));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q  <= 3'd2;
			stride_q  <= 3'd2;
			pad_q     <= 2'd0;
			height_q  <= 11'd32;
			width_q   <= 11'd32;
			row_q     <= '0;
			col_q     <= '0;
			slot_q    <= '0;
			oh_ptr_q  <= '0;
			ow_ptr_q  <= '0;
			rb_ptr_q  <= '0;
			cb_ptr_q  <= '0;
			cur_oh_q  <= '0;
			cur_ow_q  <= '0;
			cur_rb_q  <= '0;
			cur_cb_q  <= '0;
			oh_end_q  <= '0;
			ow_end_q  <= '0;
			rb_end_q  <= '0;
			cb_end_q  <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan;
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_KERNEL:  kernel_q <= cfg_data[2:0];
					REG_STRIDE:  stride_q <= cfg_data[2:0];
					REG_PADDING: pad_q    <= cfg_data[1:0];
					REG_HEIGHT:  height_q <= cfg_data;
					REG_WIDTH:   width_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				cur_oh_q <= oh_ptr_q;
				cur_rb_q <= rb_ptr_q;
				cur_ow_q <= ow_ptr_q;
				cur_cb_q <= cb_ptr_q;
			end
			if (cmd.col_step || cmd.next_col) begin
				cur_ow_q <= cur_ow_q + INDEX_BITS'(1);
				cur_cb_q <= cur_cb_q + BASE_BITS'(se);
			end
			if (cmd.row_step) begin
				cur_oh_q <= cur_oh_q + INDEX_BITS'(1);
				cur_rb_q <= cur_rb_q + BASE_BITS'(se);
			end
			if (cmd.mark) begin
				oh_end_q <= cur_oh_q;
				rb_end_q <= cur_rb_q;
				ow_end_q <= cur_ow_q;
				cb_end_q <= cur_cb_q;
				cur_oh_q <= oh_ptr_q;
				cur_rb_q <= rb_ptr_q;
				cur_ow_q <= ow_ptr_q;
				cur_cb_q <= cb_ptr_q;
			end
			if (cmd.next_row) begin
				cur_oh_q <= cur_oh_q + INDEX_BITS'(1);
				cur_rb_q <= cur_rb_q + BASE_BITS'(se);
				cur_ow_q <= ow_ptr_q;
				cur_cb_q <= cb_ptr_q;
			end
			if (cmd.adv) begin
				if (eol) begin
					col_q    <= '0;
					ow_ptr_q <= '0;
					cb_ptr_q <= '0;
					if (eop) begin
						row_q    <= '0;
						slot_q   <= '0;
						oh_ptr_q <= '0;
						rb_ptr_q <= '0;
					end else begin
						row_q    <= row_q + COORD_BITS'(1);
						slot_q   <= (slot_q == SLB'(MAX_KERNEL - 1)) ? '0 : slot_q + SLB'(1);
						oh_ptr_q <= oh_end_q;
						rb_ptr_q <= rb_end_q;
					end
				end else begin
					col_q    <= col_q + COORD_BITS'(1);
					ow_ptr_q <= ow_end_q;
					cb_ptr_q <= cb_end_q;
				end
			end
			if (cfg_hit) begin
				row_q    <= '0;
				col_q    <= '0;
				slot_q   <= '0;
				oh_ptr_q <= '0;
				ow_ptr_q <= '0;
				rb_ptr_q <= '0;
				cb_ptr_q <= '0;
			end
		end
	end

	// scan iterators and running maximum
	always_ff @(posedge clk) begin
		if (cmd.wset) begin
			h_it_q    <= ra.start;
			w_it_q    <= ca.start;
			ws_q      <= ca.start;
			slot_it_q <= slot_start;
			first_q   <= 1'b1;
			empty_q   <= ra.empty || ca.empty;
			best_q    <= MIN_VALUE;
			br_q      <= '0;
			bc_q      <= '0;
		end
		if (cmd.scan) begin
			h_s1     <= h_it_q;
			w_s1     <= w_it_q;
			first_s1 <= first_q;
			first_q  <= 1'b0;
			if (w_it_q == col_q) begin
				w_it_q    <= ws_q;
				h_it_q    <= h_it_q + COORD_BITS'(1);
				slot_it_q <= (slot_it_q == SLB'(MAX_KERNEL - 1)) ? '0 : slot_it_q + SLB'(1);
			end else begin
				w_it_q <= w_it_q + COORD_BITS'(1);
			end
		end
		if (valid_s1 && (first_s1 || ($signed(rdata) > best_q))) begin
			best_q <= $signed(rdata);
			br_q   <= h_s1;
			bc_q   <= w_s1;
		end
		if (cmd.emit) begin
			max_value <= best_q;
			max_row   <= br_q;
			max_col   <= bc_q;
			out_row   <= cur_oh_q[COORD_BITS-1:0];
			out_col   <= cur_ow_q[COORD_BITS-1:0];
			empty_res <= empty_q;
			last      <= !status.ow_more && !status.oh_more;
		end
	end
endmodule

### rtl/max_pool_2d_with_argmax.sv
// max_pool_2d_with_argmax: each sample is written to the line store, then the pointer
// search steps once per window column and per window row matched by the search;
// each closing window is set up and its n in-plane samples scanned (at most k*k, one
// line-store read per cycle; none for an empty window), then emitted after any wait on res.ready
// one sample in flight at a time; reset: kernel 2, stride 2, padding 0, 32x32 plane,
// position 0,0; line store not cleared; a registered result waits for ready
module max_pool_2d_with_argmax #(
	parameter int MAX_KERNEL  = mpa_pkg::MAX_KERNEL_DEF,
	parameter int MAX_WIDTH   = mpa_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mpa_in_if.sink     pix,
	mpa_out_if.source  res,
	mpa_cfg_if.sink    cfg
);
	import mpa_pkg::*;

	cmd_t    cmd;
	status_t status;

	// configuration transactions are always taken
	assign cfg.ready = 1'b1;

	// sequencer: take sample, find windows, scan, hand result to output register
	mpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// line store, window pointers, running max and result register
	mpa_dp #(
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.sample    (pix.sample),
		.cmd       (cmd),
		.status    (status),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.max_value (res.max_value),
		.max_row   (res.max_row),
		.max_col   (res.max_col),
		.out_row   (res.out_row),
		.out_col   (res.out_col),
		.empty_res (res.empty_res),
		.last      (res.last)
	);
endmodule

### rtl/mpa_chk.sv
// mpa_chk: port-level checks for max_pool_2d_with_argmax and its bind
// depends on mpa_pkg and the top level
module mpa_chk #(
	parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_BITS-1:0]  max_value,
	input logic [mpa_pkg::COORD_BITS-1:0] max_row,
	input logic [mpa_pkg::COORD_BITS-1:0] max_col,
	input logic                           empty_res
);
	import mpa_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] MIN_VALUE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// not ready again in the cycle after each input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// an empty window reports the minimum at the origin
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> (max_value == MIN_VALUE) && (max_row == '0)
			&& (max_col == '0))
		else $error("empty window fields wrong");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(max_value) && $stable(max_row)
			&& $stable(max_col))
		else $error("result changed while stalled");
endmodule

bind max_pool_2d_with_argmax mpa_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_mpa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix.valid),
	.in_ready  (pix.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.max_value (res.max_value),
	.max_row   (res.max_row),
	.max_col   (res.max_col),
	.empty_res (res.empty_res)
);

### tb/mpa_checker.sv
// mpa_checker: watches the sample, result and register channels of the pooling block,
// keeps its own copy of the line store and settings, and checks each result in order
// depends on mpa_pkg and the channel interfaces in mpa_if
`timescale 1ns / 100ps
module mpa_checker (
	input  logic        clk,
	input  logic        arst_n,
	mpa_in_if           pix,
	mpa_out_if          res,
	mpa_cfg_if          cfg,
	output int unsigned failures,
	output int unsigned pending,
	output int unsigned checked
);
	import mpa_pkg::*;

	typedef struct {
		logic signed [15:0] max_value;
		logic [9:0]         max_row;
		logic [9:0]         max_col;
		logic [9:0]         out_row;
		logic [9:0]         out_col;
		logic               empty_res;
		logic               last;
	} window_res_t;

	window_res_t       pool_q[$];
	logic signed [15:0] lines_mem [0:7*1024-1];
	logic [2:0]  kern_reg, step_reg;
	logic [1:0]  pad_reg;
	logic [10:0] height_reg, width_reg;
	int          next_row, next_col;

	// windows along one axis
	function automatic int win_total(int len, int k, int s, int p);
		int span;
		span = len + 2 * p - k;
		return (span < 0) ? 0 : span / s + 1;
	endfunction

	// clamped index of the sample that closes window idx
	function automatic int close_index(int idx, int len, int k, int s, int p);
		int b;
		b = idx * s - p + k;
		b = ((b < len) ? b : len) - 1;
		if (b < 0) b = 0;
		if (b > len - 1) b = len - 1;
		return b;
	endfunction

	// store the sample, queue the windows it closes, step the raster position
	task automatic pool_sample(logic signed [15:0] smp);
		int k, s, p, hh, ww, nres, hout, wout, hs, he, ws, we, br, bc;
		int best;
		bit found;
		window_res_t wr;
		k = (kern_reg == 0) ? 1 : kern_reg;
		s = (step_reg == 0) ? 1 : step_reg;
		p = pad_reg;
		hh = (height_reg < 1) ? 1 : ((height_reg > 1024) ? 1024 : height_reg);
		ww = (width_reg < 1) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
		nres = 0;
		lines_mem[(next_row % 7) * 1024 + next_col] = smp;
		hout = win_total(hh, k, s, p);
		wout = win_total(ww, k, s, p);
		for (int oh = 0; oh < hout && nres < 49; oh++) begin
			if (close_index(oh, hh, k, s, p) != next_row) continue;
			hs = oh * s - p;
			he = hs + k;
			if (hs < 0) hs = 0;
			if (he > hh) he = hh;
			for (int ow = 0; ow < wout && nres < 49; ow++) begin
				if (close_index(ow, ww, k, s, p) != next_col) continue;
				ws = ow * s - p;
				we = ws + k;
				if (ws < 0) ws = 0;
				if (we > ww) we = ww;
				found = 0;
				best = -32768;
				br = 0;
				bc = 0;
				for (int h = hs; h < he; h++) begin
					for (int w = ws; w < we; w++) begin
						// strict compare keeps the first maximum in raster order
						if (!found || lines_mem[(h % 7) * 1024 + w] > best) begin
							found = 1;
							best = lines_mem[(h % 7) * 1024 + w];
							br = h;
							bc = w;
						end
					end
				end
				wr.max_value = best[15:0];
				wr.max_row = br[9:0];
				wr.max_col = bc[9:0];
				wr.out_row = oh[9:0];
				wr.out_col = ow[9:0];
				wr.empty_res = !found;
				wr.last = 0;
				pool_q.insert(pool_q.size(), wr);
				nres++;
			end
		end
		if (nres > 0) pool_q[pool_q.size() - 1].last = 1;
		next_col++;
		if (next_col >= ww) begin
			next_col = 0;
			next_row++;
			if (next_row >= hh) next_row = 0;
		end
	endtask

	task automatic cmp_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	initial begin
		failures = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		window_res_t wr;
		if (!arst_n) begin
			kern_reg = 2;
			step_reg = 2;
			pad_reg = 0;
			height_reg = 32;
			width_reg = 32;
			next_row = 0;
			next_col = 0;
			pool_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_KERNEL:  kern_reg = cfg.data[2:0];
					REG_STRIDE:  step_reg = cfg.data[2:0];
					REG_PADDING: pad_reg = cfg.data[1:0];
					REG_HEIGHT:  height_reg = cfg.data;
					REG_WIDTH:   width_reg = cfg.data;
					default: ;
				endcase
				if (cfg.index <= REG_WIDTH) begin
					next_row = 0;
					next_col = 0;
				end
			end
			if (pix.valid && pix.ready) pool_sample(pix.sample);
			if (res.valid && res.ready) begin
				if (pool_q.size() == 0) begin
					$error("result transaction with nothing expected");
					failures++;
				end else begin
					wr = pool_q.pop_front();
					cmp_field("max_value", wr.max_value, $signed(res.max_value));
					cmp_field("max_row", wr.max_row, res.max_row);
					cmp_field("max_col", wr.max_col, res.max_col);
					cmp_field("out_row", wr.out_row, res.out_row);
					cmp_field("out_col", wr.out_col, res.out_col);
					cmp_field("empty_res", wr.empty_res, res.empty_res);
					cmp_field("last", wr.last, res.last);
					checked++;
				end
			end
		end
		pending = pool_q.size();
	end

endmodule

### tb/tb_max_pool_2d_with_argmax.sv
// tb_max_pool_2d_with_argmax: stimulus and verdict for the pooling block
// depends on mpa_pkg, mpa_if, the block and mpa_checker
`timescale 1ns / 100ps
module tb_max_pool_2d_with_argmax;
	import mpa_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int SETTLE      = 200;

	logic clk = 0;
	logic arst_n = 0;

	mpa_in_if  pix ();
	mpa_out_if res ();
	mpa_cfg_if cfg ();

	int unsigned failures, pending, checked;
	int unsigned cycles = 0;
	int unsigned samples_sent = 0;
	int unsigned settings_run = 0;
	int          burst_left = 0;

	max_pool_2d_with_argmax i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	mpa_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.res      (res),
		.cfg      (cfg),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	always #2 clk = ~clk;

	// every input known from time zero
	initial begin
		pix.valid = 0;
		pix.sample = 0;
		res.ready = 0;
		cfg.valid = 0;
		cfg.index = REG_KERNEL;
		cfg.data = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver back-pressure: the pattern steps through always ready, random, sparse,
	// long stalls and mostly ready
	always @(posedge clk) begin
		case ((cycles / 128) % 5)
			0: res.ready <= 1'b1;
			1: res.ready <= $urandom_range(0, 1);
			2: res.ready <= ($urandom_range(0, 3) == 0);
			3: res.ready <= ((cycles % 32) < 4);
			default: res.ready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// wait until every expected result has come, then let the block settle;
	// pending is first read once the checker has updated it, so the last sample transaction is already counted
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write; block must be idle, valid held through consecutive writes
	task automatic write_reg(cfg_reg_t idx, int val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val[CFG_DATA_BITS-1:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic setup(int k, int s, int p, int h, int w);
		drain();
		write_reg(REG_KERNEL, k);
		write_reg(REG_STRIDE, s);
		write_reg(REG_PADDING, p);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_WIDTH, w);
		cfg.valid <= 1'b0;
		settings_run++;
	endtask

	// one sample transaction; bursts of random length with random gaps
	task automatic send_sample(logic signed [15:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				pix.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix.valid <= 1'b1;
		pix.sample <= v;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		samples_sent++;
	endtask

	// drop valid and hold off until all results are back
	task automatic hold_off();
		pix.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// mostly full range, often a tiny range to force ties, sometimes the rails
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0, 1, 2: return 16'($urandom());
			3, 4:    return 16'($signed($urandom_range(0, 4)) - 2);
			default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic random_plane(int n, bit pause_mid);
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) hold_off();
			send_sample(pick_sample());
		end
		pix.valid <= 1'b0;
		burst_left = 0;
	endtask

	initial begin
		int k, s, p, h, w, n, random_sent;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x2 pool over a 2x4 plane at the reset kernel, rails and ties
		setup(2, 2, 0, 2, 4);
		send_sample(16'sd7);
		send_sample(16'sd7);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sd7);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		pix.valid <= 1'b0;
		// zero kernel and stride read as one; wide padding gives windows all in the border
		setup(0, 0, 3, 2, 2);
		send_sample(16'sh7fff);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sh8000);
		pix.valid <= 1'b0;
		// kernel larger than the padded plane: no windows at all
		setup(7, 7, 0, 3, 3);
		for (int i = 0; i < 9; i++) send_sample(pick_sample());
		pix.valid <= 1'b0;
		// zero plane size clamps to a single sample
		setup(2, 1, 1, 0, 0);
		send_sample(16'sh8000);
		send_sample(16'sd5);
		pix.valid <= 1'b0;

		// random settings on small planes, one or two whole planes of random content, sometimes plus part of a row
		random_sent = 0;
		while (random_sent < 280) begin
			k = $urandom_range(0, 7);
			s = $urandom_range(0, 7);
			p = $urandom_range(0, 3);
			h = $urandom_range(1, 10);
			w = $urandom_range(1, 10);
			n = h * w * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0) n = n + $urandom_range(1, w);
			setup(k, s, p, h, w);
			random_plane(n, settings_run == 5);
			random_sent += n;
		end

		// oversized height and width clamped, start of the first row only
		setup(3, 3, 0, 2047, 2047);
		random_plane(96, 1'b0);
		// largest kernel and padding over a small plane, then back to the reset values
		setup(7, 1, 3, 4, 5);
		random_plane(40, 1'b0);
		setup(2, 2, 0, 32, 32);
		random_plane(64, 1'b0);

		drain();
		$display("covered %0d samples under %0d register settings", samples_sent, settings_run);
		$display("%0d pooled results compared field by field", checked);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/mpa_pkg.sv
rtl/mpa_if.sv
rtl/mpa_ram.sv
rtl/mpa_ctrl.sv
rtl/mpa_dp.sv
rtl/max_pool_2d_with_argmax.sv
rtl/mpa_chk.sv
tb/mpa_checker.sv
tb/tb_max_pool_2d_with_argmax.sv
